FILE: rtl/core/tlb_fifo_page_table_lru_assert.svh
// Assertion macros for the translation block's checker.
// No dependencies; pulled in by `include where assertions are written.
`ifndef TLB_FIFO_PAGE_TABLE_LRU_ASSERT_SVH
`define TLB_FIFO_PAGE_TABLE_LRU_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define TLBFPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlbfpl: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define TLBFPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlbfpl: next-cycle check failed");

`endif

FILE: rtl/core/tlbfpl_pkg.sv
// Shared sizes, sequencer states and result status codes for the translation block.
// No dependencies; imported by the top level and its checker.
package tlbfpl_pkg;

    localparam int VA_W        = 16;
    localparam int PAGE_BITS   = 8;
    localparam int PAGE_W      = VA_W - PAGE_BITS;
    localparam int OFFSET_W    = PAGE_BITS;
    localparam int TLB_ENTRIES = 16;
    localparam int TLB_IDX_W   = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
    localparam int TLB_CNT_W   = $clog2(TLB_ENTRIES + 1);
    localparam int MAX_FRAMES  = 256;
    localparam int FRAME_W     = $clog2(MAX_FRAMES);
    localparam int FRAME_CNT_W = $clog2(MAX_FRAMES + 1);
    localparam int STAMP_W     = 32;
    localparam int STATUS_W    = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TLB,
        ST_PT,
        ST_LRU,
        ST_INVAL,
        ST_WRITE
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        STAT_TLB_HIT,
        STAT_PT_HIT,
        STAT_FAULT_FREE,
        STAT_FAULT_EVICT
    } t_status;

endpackage

FILE: rtl/core/tlb_fifo_page_table_lru.sv
// Top level of the address translation block: TLB, page table and LRU sequencer.
// Depends on tlbfpl_pkg and on tlbfpl_ram for the two page-table memories.
//
// One virtual address is taken per transaction when start is high and busy is
// low; exactly one result follows, shown for one cycle with o_valid high, and it
// must be captured then since the receiver cannot stall the block. The address
// splits into page (bits 15:8) and offset (bits 7:0). A single sequencer walks
// the work with one comparator per store: first the 16-slot TLB, one slot per
// cycle, then the page table over the filled frames, one frame per cycle out of
// a registered-read RAM, then on a fault with no free frame an LRU scan over the
// frames below the limit, followed by a pass over all 16 TLB slots that
// invalidates those holding the evicted page. The result strobe comes in the
// cycle busy drops. The frames_in_use register may be written at any time the
// block is idle; 0 acts as 1 and values above 256 act as 256. No clearing
// pass is needed after reset.
module tlb_fifo_page_table_lru (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [tlbfpl_pkg::VA_W-1:0]      i_virtual_address,
    input  logic                             i_cfg_we,
    input  logic [tlbfpl_pkg::FRAME_CNT_W-1:0] i_cfg_wdata,
    output logic                             o_valid,
    output logic [tlbfpl_pkg::FRAME_W-1:0]   o_frame,
    output logic [tlbfpl_pkg::OFFSET_W-1:0]  o_offset,
    output logic [tlbfpl_pkg::STATUS_W-1:0]  o_status,
    output logic [tlbfpl_pkg::PAGE_W-1:0]    o_evicted_page
);

    import tlbfpl_pkg::*;

    // Sequencer and configuration
    t_state                 r_state, n_state;
    logic [FRAME_CNT_W-1:0] r_frames_in_use, n_frames_in_use;
    logic [STAMP_W-1:0]     r_access_count, n_access_count;

    // TLB: shift queue of page/frame pairs with valid bits
    logic [PAGE_W-1:0]      r_tlb_page  [TLB_ENTRIES];
    logic [PAGE_W-1:0]      n_tlb_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     r_tlb_frame [TLB_ENTRIES];
    logic [FRAME_W-1:0]     n_tlb_frame [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0] r_tlb_valid, n_tlb_valid;
    logic [TLB_CNT_W-1:0]   r_tlb_fill, n_tlb_fill;
    logic [TLB_CNT_W-1:0]   r_tidx, n_tidx;

    // Page-table scan
    logic [FRAME_CNT_W-1:0] r_frames_filled, n_frames_filled;
    logic [FRAME_CNT_W-1:0] r_idx, n_idx;
    logic [FRAME_CNT_W-1:0] r_lim, n_lim;
    logic                   r_pend, n_pend;
    logic [FRAME_W-1:0]     r_pend_idx, n_pend_idx;
    logic [STAMP_W-1:0]     r_best, n_best;
    logic [FRAME_W-1:0]     r_best_idx, n_best_idx;
    logic [PAGE_W-1:0]      r_best_page, n_best_page;

    // Current transaction
    logic [PAGE_W-1:0]      r_page, n_page;
    logic [OFFSET_W-1:0]    r_offset, n_offset;
    logic [FRAME_W-1:0]     r_frame, n_frame;
    logic [PAGE_W-1:0]      r_evicted, n_evicted;
    t_status                r_status, n_status;

    // Result registers
    logic                   r_out_valid, n_out_valid;
    logic [FRAME_W-1:0]     r_out_frame, n_out_frame;
    logic [OFFSET_W-1:0]    r_out_offset, n_out_offset;
    t_status                r_out_status, n_out_status;
    logic [PAGE_W-1:0]      r_out_evicted, n_out_evicted;

    // Shared TLB comparator and memory ports
    logic [PAGE_W-1:0]      cmp_key;
    logic                   cmp_hit;
    logic [TLB_IDX_W-1:0]   tslot;
    logic [PAGE_W-1:0]      fp_rdata;
    logic [STAMP_W-1:0]     lu_rdata;
    logic                   fp_we, lu_we;
    logic [FRAME_CNT_W-1:0] lim;

    // Clamp the configured frame count into 1..MAX_FRAMES.
    always_comb begin
        if (r_frames_in_use == '0) begin
            lim = FRAME_CNT_W'(1);
        end else if (r_frames_in_use > FRAME_CNT_W'(MAX_FRAMES)) begin
            lim = FRAME_CNT_W'(MAX_FRAMES);
        end else begin
            lim = r_frames_in_use;
        end
    end

    // One comparator serves the lookup scan and the invalidation pass.
    assign tslot   = r_tidx[TLB_IDX_W-1:0];
    assign cmp_key = (r_state == ST_INVAL) ? r_evicted : r_page;
    assign cmp_hit = r_tlb_valid[tslot] && (r_tlb_page[tslot] == cmp_key);

    tlbfpl_ram #(
        .WIDTH (PAGE_W),
        .DEPTH (MAX_FRAMES)
    ) u_frame_page (
        .i_clk   (i_clk),
        .i_we    (fp_we),
        .i_waddr (r_frame),
        .i_wdata (r_page),
        .i_raddr (r_idx[FRAME_W-1:0]),
        .o_rdata (fp_rdata)
    );

    tlbfpl_ram #(
        .WIDTH (STAMP_W),
        .DEPTH (MAX_FRAMES)
    ) u_last_use (
        .i_clk   (i_clk),
        .i_we    (lu_we),
        .i_waddr (r_frame),
        .i_wdata (r_access_count),
        .i_raddr (r_idx[FRAME_W-1:0]),
        .o_rdata (lu_rdata)
    );

    always_comb begin
        n_state         = r_state;
        n_frames_in_use = r_frames_in_use;
        n_access_count  = r_access_count;
        n_tlb_page      = r_tlb_page;
        n_tlb_frame     = r_tlb_frame;
        n_tlb_valid     = r_tlb_valid;
        n_tlb_fill      = r_tlb_fill;
        n_tidx          = r_tidx;
        n_frames_filled = r_frames_filled;
        n_idx           = r_idx;
        n_lim           = r_lim;
        n_pend          = r_pend;
        n_pend_idx      = r_pend_idx;
        n_best          = r_best;
        n_best_idx      = r_best_idx;
        n_best_page     = r_best_page;
        n_page          = r_page;
        n_offset        = r_offset;
        n_frame         = r_frame;
        n_evicted       = r_evicted;
        n_status        = r_status;
        n_out_valid     = 1'b0;
        n_out_frame     = r_out_frame;
        n_out_offset    = r_out_offset;
        n_out_status    = r_out_status;
        n_out_evicted   = r_out_evicted;
        fp_we           = 1'b0;
        lu_we           = 1'b0;

        if (i_cfg_we) begin
            n_frames_in_use = i_cfg_wdata;
        end

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_page    = i_virtual_address[VA_W-1:PAGE_BITS];
                    n_offset  = i_virtual_address[PAGE_BITS-1:0];
                    n_evicted = '0;
                    n_tidx    = '0;
                    // saturate the stamp counter
                    if (r_access_count != '1) begin
                        n_access_count = r_access_count + 1'b1;
                    end
                    n_state = ST_TLB;
                end
            end

            ST_TLB: begin
                if (r_tidx >= r_tlb_fill) begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = ST_PT;
                end else if (cmp_hit) begin
                    n_frame  = r_tlb_frame[tslot];
                    n_status = STAT_TLB_HIT;
                    n_state  = ST_WRITE;
                end else begin
                    n_tidx = r_tidx + 1'b1;
                end
            end

            ST_PT: begin
                // compare the frame read last cycle while issuing the next read
                if (r_pend && (fp_rdata == r_page)) begin
                    n_frame  = r_pend_idx;
                    n_status = STAT_PT_HIT;
                    if (r_tlb_fill < TLB_CNT_W'(TLB_ENTRIES)) begin
                        n_tlb_page[r_tlb_fill[TLB_IDX_W-1:0]]  = r_page;
                        n_tlb_frame[r_tlb_fill[TLB_IDX_W-1:0]] = r_pend_idx;
                        n_tlb_valid[r_tlb_fill[TLB_IDX_W-1:0]] = 1'b1;
                        n_tlb_fill = r_tlb_fill + 1'b1;
                    end else begin
                        // full: advance the queue and drop the oldest slot
                        for (int k = 1; k < TLB_ENTRIES; k++) begin
                            n_tlb_page[k-1]  = r_tlb_page[k];
                            n_tlb_frame[k-1] = r_tlb_frame[k];
                            n_tlb_valid[k-1] = r_tlb_valid[k];
                        end
                        n_tlb_page[TLB_ENTRIES-1]  = r_page;
                        n_tlb_frame[TLB_ENTRIES-1] = r_pend_idx;
                        n_tlb_valid[TLB_ENTRIES-1] = 1'b1;
                    end
                    n_state = ST_WRITE;
                end else if (r_idx < r_frames_filled) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[FRAME_W-1:0];
                    n_idx      = r_idx + 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else if (r_frames_filled < lim) begin
                    n_frame         = r_frames_filled[FRAME_W-1:0];
                    n_frames_filled = r_frames_filled + 1'b1;
                    n_status        = STAT_FAULT_FREE;
                    n_state         = ST_WRITE;
                end else begin
                    n_lim   = lim;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_best  = '1;
                    n_state = ST_LRU;
                end
            end

            ST_LRU: begin
                // less-or-equal keeps the highest index among equal stamps
                if (r_pend && (lu_rdata <= r_best)) begin
                    n_best      = lu_rdata;
                    n_best_idx  = r_pend_idx;
                    n_best_page = fp_rdata;
                end
                if (r_idx < r_lim) begin
                    n_pend     = 1'b1;
                    n_pend_idx = r_idx[FRAME_W-1:0];
                    n_idx      = r_idx + 1'b1;
                end else if (r_pend) begin
                    n_pend = 1'b0;
                end else begin
                    n_frame   = r_best_idx;
                    n_evicted = r_best_page;
                    n_status  = STAT_FAULT_EVICT;
                    n_tidx    = '0;
                    n_state   = ST_INVAL;
                end
            end

            ST_INVAL: begin
                // invalidated slots keep their place in the queue
                if (cmp_hit) begin
                    n_tlb_valid[tslot] = 1'b0;
                end
                if (r_tidx == TLB_CNT_W'(TLB_ENTRIES - 1)) begin
                    n_state = ST_WRITE;
                end else begin
                    n_tidx = r_tidx + 1'b1;
                end
            end

            ST_WRITE: begin
                lu_we         = 1'b1;
                fp_we         = (r_status == STAT_FAULT_FREE) ||
                                (r_status == STAT_FAULT_EVICT);
                n_out_valid   = 1'b1;
                n_out_frame   = r_frame;
                n_out_offset  = r_offset;
                n_out_status  = r_status;
                n_out_evicted = r_evicted;
                n_state       = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_IDLE;
            r_frames_in_use <= FRAME_CNT_W'(MAX_FRAMES);
            r_access_count  <= '0;
            r_tlb_valid     <= '0;
            r_tlb_fill      <= '0;
            r_frames_filled <= '0;
            r_pend          <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_frames_in_use <= n_frames_in_use;
            r_access_count  <= n_access_count;
            r_tlb_valid     <= n_tlb_valid;
            r_tlb_fill      <= n_tlb_fill;
            r_frames_filled <= n_frames_filled;
            r_pend          <= n_pend;
            r_out_valid     <= n_out_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_tlb_page    <= n_tlb_page;
        r_tlb_frame   <= n_tlb_frame;
        r_tidx        <= n_tidx;
        r_idx         <= n_idx;
        r_lim         <= n_lim;
        r_pend_idx    <= n_pend_idx;
        r_best        <= n_best;
        r_best_idx    <= n_best_idx;
        r_best_page   <= n_best_page;
        r_page        <= n_page;
        r_offset      <= n_offset;
        r_frame       <= n_frame;
        r_evicted     <= n_evicted;
        r_status      <= n_status;
        r_out_frame   <= n_out_frame;
        r_out_offset  <= n_out_offset;
        r_out_status  <= n_out_status;
        r_out_evicted <= n_out_evicted;
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_frame        = r_out_frame;
    assign o_offset       = r_out_offset;
    assign o_status       = r_out_status;
    assign o_evicted_page = r_out_evicted;

endmodule

FILE: rtl/core/tlbfpl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the page table's page numbers and use stamps.
module tlbfpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/tlbfpl_checker.sv
// Port-level checker for the translation block, bound to the top level.
// Depends on tlbfpl_pkg and the assertion macros in tlb_fifo_page_table_lru_assert.svh.
`include "tlb_fifo_page_table_lru_assert.svh"

module tlbfpl_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             o_valid,
    input logic [tlbfpl_pkg::STATUS_W-1:0]  o_status,
    input logic [tlbfpl_pkg::PAGE_W-1:0]    o_evicted_page
);

    import tlbfpl_pkg::*;

    // an accepted transaction occupies the sequencer
    `TLBFPL_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // a result strobe lasts one cycle only
    `TLBFPL_ASSERT_NEXT(a_strobe_pulse, i_clk, i_rst_n, o_valid, !o_valid)
    // the result appears once the block has gone idle
    `TLBFPL_ASSERT_NOW(a_strobe_idle, i_clk, i_rst_n, o_valid, !busy)
    // only an eviction reports a removed page
    `TLBFPL_ASSERT_NOW(a_evict_zero, i_clk, i_rst_n,
        o_valid && (o_status != STAT_FAULT_EVICT), o_evicted_page == '0)

endmodule

bind tlb_fifo_page_table_lru tlbfpl_checker u_tlbfpl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_valid        (o_valid),
    .o_status       (o_status),
    .o_evicted_page (o_evicted_page)
);

FILE: dv/tlb_fifo_page_table_lru_tb.sv
// Self-checking testbench for the address translation block tlb_fifo_page_table_lru.
// Depends on tlbfpl_pkg for sizes and status codes and on the block's RTL; nothing else.
// Drives addresses through the start/busy handshake and checks each strobed result in order.
module tlb_fifo_page_table_lru_tb;
    import tlbfpl_pkg::*;

    // Watchdog limit allows several times the longest correct busy period.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 600;

    typedef struct packed {
        logic [FRAME_W-1:0]  frame;
        logic [OFFSET_W-1:0] offset;
        t_status             status;
        logic [PAGE_W-1:0]   evicted_page;
    } t_xlat;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [VA_W-1:0]        i_virtual_address;
    logic                   i_cfg_we;
    logic [FRAME_CNT_W-1:0] i_cfg_wdata;
    logic                   o_valid;
    logic [FRAME_W-1:0]     o_frame;
    logic [OFFSET_W-1:0]    o_offset;
    logic [STATUS_W-1:0]    o_status;
    logic [PAGE_W-1:0]      o_evicted_page;

    tlb_fifo_page_table_lru u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_virtual_address (i_virtual_address),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_valid           (o_valid),
        .o_frame           (o_frame),
        .o_offset          (o_offset),
        .o_status          (o_status),
        .o_evicted_page    (o_evicted_page)
    );

    // ------------------------------------------------------------------
    // Shadow copy of the translation state, advanced once per accepted
    // transaction. TLB page/frame and page-table entries are only read
    // behind a valid bit or below the fill count.
    // ------------------------------------------------------------------
    logic [PAGE_W-1:0]      tlb_slot_page  [TLB_ENTRIES];
    logic [FRAME_W-1:0]     tlb_slot_frame [TLB_ENTRIES];
    bit                     tlb_slot_valid [TLB_ENTRIES];
    int unsigned            tlb_used;
    logic [PAGE_W-1:0]      pt_page  [MAX_FRAMES];
    logic [STAMP_W-1:0]     pt_stamp [MAX_FRAMES];
    int unsigned            frames_used;
    logic [STAMP_W-1:0]     access_cnt;
    logic [FRAME_CNT_W-1:0] frame_limit_reg;

    t_xlat       expected_xlat[$];
    int unsigned mismatch_count;
    int unsigned stall_cycles;

    // Translate one address and update the shadow state exactly as the block does.
    function automatic t_xlat translate_address(input logic [VA_W-1:0] va);
        t_xlat              res;
        logic [PAGE_W-1:0]  page;
        int unsigned        lim;
        int unsigned        frm;
        logic [STAMP_W-1:0] oldest;
        bit                 found;
        page             = va[VA_W-1:PAGE_BITS];
        res.offset       = va[OFFSET_W-1:0];
        res.evicted_page = '0;
        res.status       = STAT_TLB_HIT;
        frm              = 0;
        found            = 1'b0;
        // Saturate the stamp counter at all ones.
        if (access_cnt != {STAMP_W{1'b1}}) access_cnt = access_cnt + 1'b1;

        // TLB lookup: first valid slot with the page wins.
        for (int k = 0; k < int'(tlb_used); k++) begin
            if (!found && tlb_slot_valid[k] && tlb_slot_page[k] == page) begin
                frm   = 32'(tlb_slot_frame[k]);
                found = 1'b1;
            end
        end

        if (!found) begin
            // Page table search over every filled frame, even those above the limit.
            for (int k = 0; k < int'(frames_used); k++) begin
                if (!found && pt_page[k] == page) begin
                    frm   = k;
                    found = 1'b1;
                end
            end
            if (found) begin
                res.status = STAT_PT_HIT;
                // Append to the TLB queue; when full, shift everything down and drop slot 0.
                if (tlb_used < TLB_ENTRIES) begin
                    tlb_slot_page[tlb_used]  = page;
                    tlb_slot_frame[tlb_used] = frm[FRAME_W-1:0];
                    tlb_slot_valid[tlb_used] = 1'b1;
                    tlb_used++;
                end else begin
                    for (int k = 1; k < TLB_ENTRIES; k++) begin
                        tlb_slot_page[k-1]  = tlb_slot_page[k];
                        tlb_slot_frame[k-1] = tlb_slot_frame[k];
                        tlb_slot_valid[k-1] = tlb_slot_valid[k];
                    end
                    tlb_slot_page[TLB_ENTRIES-1]  = page;
                    tlb_slot_frame[TLB_ENTRIES-1] = frm[FRAME_W-1:0];
                    tlb_slot_valid[TLB_ENTRIES-1] = 1'b1;
                end
            end else begin
                // Clamp the limit: zero behaves as one, anything past the table as the table.
                if (frame_limit_reg == 0)               lim = 1;
                else if (frame_limit_reg > MAX_FRAMES)  lim = MAX_FRAMES;
                else                                    lim = 32'(frame_limit_reg);
                if (frames_used < lim) begin
                    frm = frames_used;
                    frames_used++;
                    res.status = STAT_FAULT_FREE;
                end else begin
                    // LRU over frames below the limit; ties go to the highest index.
                    oldest = {STAMP_W{1'b1}};
                    for (int k = 0; k < int'(lim); k++) begin
                        if (pt_stamp[k] <= oldest) begin
                            oldest = pt_stamp[k];
                            frm    = k;
                        end
                    end
                    res.evicted_page = pt_page[frm];
                    // Drop any TLB slot still mapping the victim page; the slot keeps its place.
                    for (int k = 0; k < TLB_ENTRIES; k++) begin
                        if (tlb_slot_valid[k] && tlb_slot_page[k] == res.evicted_page)
                            tlb_slot_valid[k] = 1'b0;
                    end
                    res.status = STAT_FAULT_EVICT;
                end
                pt_page[frm] = page;
            end
        end

        pt_stamp[frm] = access_cnt;
        res.frame     = frm[FRAME_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Clock, result checker and watchdog
    // ------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Compare every strobed result against the oldest pending translation.
    always @(posedge i_clk) begin
        t_xlat want;
        if (i_rst_n && o_valid) begin
            if (expected_xlat.size() == 0) begin
                $error("unexpected result: frame %0d offset %0d status %0d evicted_page %0d",
                       o_frame, o_offset, o_status, o_evicted_page);
                mismatch_count++;
            end else begin
                want = expected_xlat.pop_front();
                if (o_frame !== want.frame) begin
                    $error("frame mismatch: expected %0d, actual %0d", want.frame, o_frame);
                    mismatch_count++;
                end
                if (o_offset !== want.offset) begin
                    $error("offset mismatch: expected %0d, actual %0d", want.offset, o_offset);
                    mismatch_count++;
                end
                if (o_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d", want.status, o_status);
                    mismatch_count++;
                end
                if (o_evicted_page !== want.evicted_page) begin
                    $error("evicted_page mismatch: expected %0d, actual %0d",
                           want.evicted_page, o_evicted_page);
                    mismatch_count++;
                end
            end
        end
    end

    // Abort when neither side moves a transaction for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver tasks: inputs change on the falling edge only
    // ------------------------------------------------------------------

    // Present one address and hold it until the block takes it; leave start high.
    task automatic issue_address(input logic [VA_W-1:0] va);
        @(negedge i_clk);
        start             <= 1'b1;
        i_virtual_address <= va;
        do @(posedge i_clk); while (busy);
        expected_xlat.push_back(translate_address(va));
    endtask

    // Hold start low for the given gap and scramble the idle address bus.
    task automatic hold_off(input int unsigned n);
        repeat (n) begin
            @(negedge i_clk);
            start             <= 1'b0;
            i_virtual_address <= VA_W'($urandom);
        end
    endtask

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int unsigned pick_gap(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 50) return 0;
        if (r < 90)          return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Lower start and wait until every pending translation has come back.
    task automatic wait_results_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_xlat.size() != 0) @(posedge i_clk);
    endtask

    // Write the frame limit with the block idle; the shadow copy follows at the write edge.
    task automatic set_frame_limit(input logic [FRAME_CNT_W-1:0] val);
        wait_results_drained();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        frame_limit_reg = val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= FRAME_CNT_W'($urandom);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Limit of zero acts as one frame: fill it, hit it twice, then thrash it with
    // address extremes so the TLB entry for the victim gets invalidated.
    task automatic test_frame_limit_floor();
        set_frame_limit('0);
        issue_address(16'h0000);  // fault into free frame 0
        issue_address(16'h0000);  // page table hit, loads TLB
        issue_address(16'h00FF);  // TLB hit
        issue_address(16'hFFFF);  // evict page 0, kill its TLB slot
        issue_address(16'h0000);  // must miss the dead TLB slot
        issue_address(16'hFF00);  // evict again
    endtask

    // Fill frames under a high limit, then lower it: upper frames stay searchable,
    // replacement stays below the new limit.
    task automatic test_limit_lowered();
        set_frame_limit(9'd4);
        issue_address(16'h1001);
        issue_address(16'h1102);
        issue_address(16'h1203);
        set_frame_limit(9'd511);  // clamps to the full table
        issue_address(16'h1380);
        issue_address(16'h14FE);
        set_frame_limit(9'd2);
        issue_address(16'h1455);  // hit in a frame above the limit
        issue_address(16'h20AA);  // evict within frames 0..1
        issue_address(16'h2133);
        issue_address(16'h13C3);  // another hit above the limit
        issue_address(16'h1010);
    endtask

    // Random phases over a ladder of limits, small ones first so the page table
    // stays short while most traffic runs; the largest settings come last.
    task automatic test_random_phases();
        int unsigned limits [12] = '{3, 1, 8, 16, 5, 24, 2, 48, 64, 257, 256, 511};
        int unsigned counts [12] = '{120, 120, 120, 120, 120, 120, 120, 120, 120, 110, 110, 110};
        int unsigned eff;
        int unsigned ws;
        int unsigned base;
        int unsigned gap;
        bit          quiet;
        logic [PAGE_W-1:0] page;
        for (int p = 0; p < 12; p++) begin
            set_frame_limit(limits[p][FRAME_CNT_W-1:0]);
            eff   = (limits[p] > MAX_FRAMES) ? MAX_FRAMES : limits[p];
            // Working set slightly larger than the limit keeps hits and evictions mixed.
            ws    = eff + $urandom_range(0, eff / 2 + 2);
            base  = $urandom_range(0, 255);
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < int'(counts[p]); n++) begin
                if ($urandom_range(0, 99) < 75)
                    page = PAGE_W'(base + $urandom_range(0, ws - 1));
                else
                    page = PAGE_W'($urandom);
                issue_address({page, OFFSET_W'($urandom)});
                gap = pick_gap(quiet);
                if (gap != 0) hold_off(gap);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_virtual_address = '0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = '0;
        mismatch_count    = 0;
        stall_cycles      = 0;
        tlb_used          = 0;
        frames_used       = 0;
        access_cnt        = '0;
        frame_limit_reg   = 9'd256;
        for (int k = 0; k < TLB_ENTRIES; k++) begin
            tlb_slot_page[k]  = '0;
            tlb_slot_frame[k] = '0;
            tlb_slot_valid[k] = 1'b0;
        end
        for (int k = 0; k < MAX_FRAMES; k++) begin
            pt_page[k]  = '0;
            pt_stamp[k] = '0;
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_frame_limit_floor();
        test_limit_lowered();
        test_random_phases();

        // Let the last results land, then watch for strays.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0 && expected_xlat.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
